>>> hw/rtl/sitoa_pkg.sv
// shared types and constants for the signed integer to decimal text converter
// no dependencies
`default_nettype none

package sitoa_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = 10;
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_STEPS   = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W  = $clog2(NUM_STEPS);
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

  typedef logic [DIGIT_W-1:0]       digit_t;
  typedef logic [CHAR_W-1:0]        char_t;
  typedef logic [BITS_PER_STEP-1:0] bit_group_t;

  localparam char_t CHAR_MINUS = 7'd45;
  localparam char_t CHAR_ZERO  = 7'd48;

  // controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sitoa_in_if.sv
// input channel: one signed integer per transaction
// depends on sitoa_pkg
`default_nettype none

interface sitoa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitoa_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sitoa_out_if.sv
// output channel: one ascii character per transaction
// depends on sitoa_pkg
`default_nettype none

interface sitoa_out_if;
  logic                  valid;
  logic                  ready;
  sitoa_pkg::char_t      character;
  logic                  last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sitoa_cell.sv
// one bcd digit cell of the double-dabble chain, four binary bits per cycle while shift is set
// depends on sitoa_pkg
`default_nettype none

module sitoa_cell (
  input  wire logic                  clk,
  input  wire sitoa_pkg::cell_ctrl_t ctrl,
  input  wire sitoa_pkg::bit_group_t bits_in,
  output sitoa_pkg::bit_group_t      bits_out,
  output sitoa_pkg::digit_t          digit
);

  sitoa_pkg::digit_t digit_next;

  // bits travel msb first: bits_in[3] enters before bits_in[0]
  always_comb begin
    sitoa_pkg::digit_t d;
    sitoa_pkg::digit_t adj;
    d        = digit;
    bits_out = '0;
    for (int k = 0; k < sitoa_pkg::BITS_PER_STEP; k++) begin
      adj = (d >= sitoa_pkg::digit_t'(5)) ? sitoa_pkg::digit_t'(d + 4'd3) : d;
      bits_out[sitoa_pkg::BITS_PER_STEP-1-k] = adj[sitoa_pkg::DIGIT_W-1];
      d = {adj[sitoa_pkg::DIGIT_W-2:0], bits_in[sitoa_pkg::BITS_PER_STEP-1-k]};
    end
    digit_next = d;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= digit_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text. Each input transaction carries
// one two's complement value; the block answers with its decimal text, one
// character per output transaction, most significant digit first, a leading
// '-' for negative values, no leading zeros ('0' for zero), and last set on
// the final character. The magnitude is shifted four bits a cycle into a
// chain of ten bcd cells; the leading digit is then found in its own state,
// and the characters leave one at a time, each as the output register is
// free or being taken. A new value is taken as soon as the last character
// is in the output register, while that character still waits to be taken.
// depends on sitoa_pkg, sitoa_in_if, sitoa_out_if, sitoa_cell
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic     clk,
  input  wire logic     rst,
  sitoa_in_if.sink      in_ch,
  sitoa_out_if.source   out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [sitoa_pkg::VALUE_W-1:0]     mag;
  logic                              neg_pending;
  logic [sitoa_pkg::STEP_CNT_W-1:0]  step_cnt;
  logic [sitoa_pkg::DIGIT_IDX_W-1:0] idx;
  logic [sitoa_pkg::DIGIT_IDX_W-1:0] lead_idx;

  logic              out_valid;
  sitoa_pkg::char_t  out_char;
  logic              out_last;

  logic accept;
  logic emit_fire;
  logic [sitoa_pkg::VALUE_W-1:0] raw;

  sitoa_pkg::cell_ctrl_t ctrl;
  sitoa_pkg::bit_group_t chain [sitoa_pkg::NUM_DIGITS+1];
  sitoa_pkg::digit_t     digits [sitoa_pkg::NUM_DIGITS];

  assign in_ch.ready      = (state == ST_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign raw              = $unsigned(in_ch.value);
  assign emit_fire        = (state == ST_EMIT) && (!out_valid || out_ch.ready);

  assign out_ch.valid     = out_valid;
  assign out_ch.character = out_char;
  assign out_ch.last      = out_last;

  assign ctrl.clear = accept;
  assign ctrl.shift = (state == ST_CONV);

  // magnitude enters the chain msb first, top nibble each cycle
  assign chain[0] = mag[sitoa_pkg::VALUE_W-1 -: sitoa_pkg::BITS_PER_STEP];

  for (genvar i = 0; i < sitoa_pkg::NUM_DIGITS; i++) begin : g_cell
    sitoa_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bits_in  (chain[i]),
      .bits_out (chain[i+1]),
      .digit    (digits[i])
    );
  end

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < sitoa_pkg::NUM_DIGITS; i++) begin
      if (digits[i] != '0) begin
        lead_idx = sitoa_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (step_cnt == sitoa_pkg::STEP_CNT_W'(sitoa_pkg::NUM_STEPS - 1)) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire && !neg_pending && idx == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag         <= raw[sitoa_pkg::VALUE_W-1] ? (sitoa_pkg::VALUE_W'(0) - raw) : raw;
      neg_pending <= raw[sitoa_pkg::VALUE_W-1];
      step_cnt    <= '0;
    end else if (state == ST_CONV) begin
      mag      <= mag << sitoa_pkg::BITS_PER_STEP;
      step_cnt <= step_cnt + 1'b1;
    end

    if (state == ST_FIND) begin
      idx <= lead_idx;
    end

    if (emit_fire) begin
      if (neg_pending) begin
        out_char    <= sitoa_pkg::CHAR_MINUS;
        out_last    <= 1'b0;
        neg_pending <= 1'b0;
      end else begin
        out_char <= sitoa_pkg::CHAR_ZERO + sitoa_pkg::CHAR_W'(digits[idx]);
        out_last <= (idx == '0);
        if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
